/* sv/context_window_chunk_planner_macros.svh */
// Assertion macros shared by the chunk planner modules.
`ifndef CONTEXT_WINDOW_CHUNK_PLANNER_MACROS_SVH
`define CONTEXT_WINDOW_CHUNK_PLANNER_MACROS_SVH
`ifndef SYNTH
`define CWCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("chunk planner check failed");
`define CWCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chunk planner check failed");
`else
`define CWCP_ASSERT(lbl, prop)
`define CWCP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/cwcp_pkg.sv */
// Shared types and constants of the chunk planner.
package cwcp_pkg;

  localparam int ADDR_BITS = 5;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_BITS = 2;
  localparam int OUTQ_CNT_BITS = 3;

  localparam logic [15:0] WIN_LEN_RESET = 16'd1024;

  typedef enum logic [2:0] {
    REG_WIN_LEN        = 3'd0,
    REG_CONTEXT_BEFORE = 3'd1,
    REG_CONTEXT_AFTER  = 3'd2,
    REG_END_ALIGN      = 3'd3,
    REG_SIGNAL_LENGTH  = 3'd4
  } cwcp_reg_t;

  typedef struct packed {
    logic [31:0] signal_length;
    logic        end_align;
    logic [15:0] context_after;
    logic [15:0] context_before;
    logic [15:0] win_len;
  } cwcp_cfg_t;

  // results pushed into the output queue in one cycle; slot a is always used first
  typedef struct packed {
    logic push_a;
    logic push_b;
    logic last_a;
    logic last_b;
  } cwcp_push_t;

endpackage

/* sv/cwcp_cfg.sv */
// APB register file holding the planner settings.
module cwcp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cwcp_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output cwcp_pkg::cwcp_cfg_t              cfg
);
  import cwcp_pkg::*;

  logic      wr_en;
  cwcp_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = cwcp_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_len        <= WIN_LEN_RESET;
      cfg.context_before <= '0;
      cfg.context_after  <= '0;
      cfg.end_align      <= 1'b0;
      cfg.signal_length  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIN_LEN:        cfg.win_len        <= pwdata[15:0];
        REG_CONTEXT_BEFORE: cfg.context_before <= pwdata[15:0];
        REG_CONTEXT_AFTER:  cfg.context_after  <= pwdata[15:0];
        REG_END_ALIGN:      cfg.end_align      <= pwdata[0];
        REG_SIGNAL_LENGTH:  cfg.signal_length  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIN_LEN:        prdata = {16'd0, cfg.win_len};
      REG_CONTEXT_BEFORE: prdata = {16'd0, cfg.context_before};
      REG_CONTEXT_AFTER:  prdata = {16'd0, cfg.context_after};
      REG_END_ALIGN:      prdata = {31'd0, cfg.end_align};
      REG_SIGNAL_LENGTH:  prdata = cfg.signal_length;
      default:            prdata = '0;
    endcase
  end

endmodule

/* sv/cwcp_core.sv */
// Input register, per-hit chunk decision and read state of the planner.
`include "context_window_chunk_planner_macros.svh"
module cwcp_core #(
  parameter int P = 32,
  parameter int I = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cwcp_pkg::cwcp_cfg_t   cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [P-1:0]          in_hit_position,
  input  logic                  in_final,
  input  logic                  room,
  output cwcp_pkg::cwcp_push_t  push,
  output logic [P+I-1:0]        data_a,
  output logic [P+I-1:0]        data_b
);
  import cwcp_pkg::*;

  localparam int W  = P + 3;                   // signed working width
  localparam int NW = P + 2;                   // next start register width
  localparam int LW = (NW > 32) ? NW : 32;     // compare width against signal length
  localparam logic signed [W-1:0] ONE_W = W'(1);
  localparam logic signed [W-1:0] ZERO_W = '0;
  localparam logic signed [W-1:0] POS_MAX_W = {3'b000, {P{1'b1}}};

  // input register
  logic         in_full;
  logic [P-1:0] hit;
  logic         last;
  logic         consume;

  // read state
  logic [NW-1:0] next_start, next_start_next;
  logic [I-1:0]  hit_counter, hit_counter_next;
  logic          held_valid, held_valid_next;
  logic [P-1:0]  held_start, held_start_next;
  logic [I-1:0]  held_hit_index, held_hit_index_next;
  logic          chunks_before_held, chunks_before_held_next;

  logic                 opens;
  logic [P-1:0]         cb_p;
  logic [P-1:0]         start;
  logic signed [W-1:0]  hit_w, start_w, cs_w, ca_w, cand, nxt_w, aligned;
  logic [P-1:0]         final_start;
  logic                 hv1, cbh1;
  logic [P-1:0]         hs1;
  logic [I-1:0]         hi1;

  assign consume  = in_full & room;
  assign in_ready = ~in_full | room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hit  <= in_hit_position;
      last <= in_final;
    end
  end

  // chunk arithmetic
  always_comb begin
    cb_p    = P'(cfg.context_before);
    start   = (hit >= cb_p) ? (hit - cb_p) : '0;
    hit_w   = $signed({3'b000, hit});
    start_w = $signed({3'b000, start});
    cs_w    = $signed({{(W-16){1'b0}}, cfg.win_len});
    ca_w    = $signed({{(W-16){1'b0}}, cfg.context_after});
    cand    = start_w + cs_w - ca_w + ONE_W;
    nxt_w   = (cand <= hit_w) ? (hit_w + ONE_W) : cand;
    aligned = hit_w + ca_w - cs_w;
    opens   = (LW'(next_start) < LW'(cfg.signal_length)) && ({2'b00, hit} >= next_start);
  end

  always_comb begin
    hv1  = held_valid | opens;
    cbh1 = chunks_before_held | (opens & held_valid);
    hs1  = opens ? start : held_start;
    hi1  = opens ? hit_counter : held_hit_index;

    final_start = hs1;
    if (cbh1 && cfg.end_align && aligned > ZERO_W) begin
      final_start = (aligned > POS_MAX_W) ? {P{1'b1}} : aligned[P-1:0];
    end

    push   = '0;
    data_a = {held_hit_index, held_start};
    data_b = {hi1, final_start};
    if (consume) begin
      if (opens && held_valid) begin
        push.push_a = 1'b1;
        push.last_a = 1'b0;
        if (last) begin
          push.push_b = 1'b1;
          push.last_b = 1'b1;
        end
      end else if (last && hv1) begin
        push.push_a = 1'b1;
        push.last_a = 1'b1;
        data_a      = {hi1, final_start};
      end
    end

    next_start_next         = next_start;
    hit_counter_next        = hit_counter;
    held_valid_next         = held_valid;
    held_start_next         = held_start;
    held_hit_index_next     = held_hit_index;
    chunks_before_held_next = chunks_before_held;
    if (consume) begin
      if (last) begin
        next_start_next         = '0;
        hit_counter_next        = '0;
        held_valid_next         = 1'b0;
        chunks_before_held_next = 1'b0;
      end else begin
        hit_counter_next        = hit_counter + I'(1);
        held_valid_next         = hv1;
        held_start_next         = hs1;
        held_hit_index_next     = hi1;
        chunks_before_held_next = cbh1;
        if (opens) begin
          next_start_next = nxt_w[NW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_start         <= '0;
      hit_counter        <= '0;
      held_valid         <= 1'b0;
      chunks_before_held <= 1'b0;
    end else begin
      next_start         <= next_start_next;
      hit_counter        <= hit_counter_next;
      held_valid         <= held_valid_next;
      chunks_before_held <= chunks_before_held_next;
    end
  end

  always_ff @(posedge clk) begin
    held_start     <= held_start_next;
    held_hit_index <= held_hit_index_next;
  end

  `CWCP_ASSERT_NEXT(a_read_clears, consume && last, hit_counter == '0 && !held_valid)
  `CWCP_ASSERT(a_cbh_needs_held, !chunks_before_held || held_valid)
  `CWCP_ASSERT(a_slot_order, !push.push_b || push.push_a)

endmodule

/* sv/cwcp_outq.sv */
// Four-entry result queue taking up to two chunks per cycle.
`include "context_window_chunk_planner_macros.svh"
module cwcp_outq #(
  parameter int DW = 56
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cwcp_pkg::cwcp_push_t  push,
  input  logic [DW-1:0]         data_a,
  input  logic [DW-1:0]         data_b,
  output logic                  room,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [DW-1:0]         q_data,
  output logic                  q_last
);
  import cwcp_pkg::*;

  logic [DW:0]              entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_BITS-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [OUTQ_CNT_BITS-1:0] count, count_next;
  logic                     pop;

  assign pop     = q_valid & q_ready;
  assign q_valid = (count != '0);
  assign room    = (count <= OUTQ_CNT_BITS'(OUTQ_DEPTH - 2));
  assign {q_last, q_data} = entries[rd_ptr];

  always_comb begin
    count_next  = count + OUTQ_CNT_BITS'(push.push_a) + OUTQ_CNT_BITS'(push.push_b)
                  - OUTQ_CNT_BITS'(pop);
    wr_ptr_next = wr_ptr + OUTQ_PTR_BITS'(push.push_a) + OUTQ_PTR_BITS'(push.push_b);
    rd_ptr_next = rd_ptr + OUTQ_PTR_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      entries[wr_ptr] <= {push.last_a, data_a};
    end
    if (push.push_b) begin
      entries[wr_ptr + OUTQ_PTR_BITS'(1)] <= {push.last_b, data_b};
    end
  end

  `CWCP_ASSERT(a_no_overflow, count <= OUTQ_CNT_BITS'(OUTQ_DEPTH))
  `CWCP_ASSERT_NEXT(a_push_nonempty, push.push_a && !pop, count != '0)
  `CWCP_ASSERT_NEXT(a_idle_holds, !push.push_a && !pop, $stable(count))

endmodule

/* sv/context_window_chunk_planner.sv */
// Top level of the motif-hit context window chunk planner.
// Accepts one hit per cycle on the s_ side and delivers chunks on the m_ side through the
// input register and then the result queue. A hit that opens a new chunk while another
// is held, and is also the last hit of the read, yields two chunks, sent one after the
// other. The input stalls only while the four-entry result queue has fewer than two free
// entries, so sustained rate is one hit per cycle as long as m_tready stays high and on
// average at most one chunk is made per hit. The newest chunk of a read is held back until
// the next chunk opens or the last hit arrives.
module context_window_chunk_planner #(
  parameter int POSITION_BITS = 32,
  parameter int INDEX_BITS    = 24
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             psel,
  input  logic                                             penable,
  input  logic                                             pwrite,
  input  logic [cwcp_pkg::ADDR_BITS-1:0]                   paddr,
  input  logic [31:0]                                      pwdata,
  output logic [31:0]                                      prdata,
  output logic                                             pready,
  input  logic                                             s_tvalid,
  output logic                                             s_tready,
  input  logic [((POSITION_BITS+7)/8)*8-1:0]               s_tdata, // hit_position
  input  logic                                             s_tlast, // final hit of the read
  output logic                                             m_tvalid,
  input  logic                                             m_tready,
  // window begin, first_hit_index
  output logic [((POSITION_BITS+INDEX_BITS+7)/8)*8-1:0]    m_tdata,
  output logic                                             m_tlast  // last_chunk
);
  import cwcp_pkg::*;

  localparam int OUT_W = ((POSITION_BITS + INDEX_BITS + 7) / 8) * 8;
  localparam int RW    = POSITION_BITS + INDEX_BITS;

  cwcp_cfg_t         cfg;
  cwcp_push_t        push;
  logic              room;
  logic [RW-1:0]     data_a, data_b, q_data;

  cwcp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cwcp_core #(
    .P (POSITION_BITS),
    .I (INDEX_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_hit_position (s_tdata[POSITION_BITS-1:0]),
    .in_final        (s_tlast),
    .room            (room),
    .push            (push),
    .data_a          (data_a),
    .data_b          (data_b)
  );

  cwcp_outq #(
    .DW (RW)
  ) u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .data_a  (data_a),
    .data_b  (data_b),
    .room    (room),
    .q_valid (m_tvalid),
    .q_ready (m_tready),
    .q_data  (q_data),
    .q_last  (m_tlast)
  );

  assign m_tdata = OUT_W'(q_data);

endmodule

/* verif/cwcp_checker.sv */
// Checker for the chunk planner: mirrors the registers, predicts chunks, compares the m_ stream.
module cwcp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [cwcp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic [31:0]                    prdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [31:0]                    s_tdata,  // hit_position
  input  logic                           s_tlast,  // final hit of the read
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [55:0]                    m_tdata,  // window begin, first_hit_index
  input  logic                           m_tlast,  // last_chunk
  output int                             fail_count,
  output int                             pending,
  output int                             chunks_seen,
  output int                             hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import cwcp_pkg::*;

  localparam longint POS_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] start;
    logic [23:0] hit_idx;
    logic        last;
  } chunk_t;

  chunk_t chunk_q[$];

  // register mirror
  logic [15:0] cs, cb, ca;
  logic        ea;
  logic [31:0] sl;

  // per-read planner state
  longint      next_start;
  logic [23:0] hit_cnt;
  logic        held_v;
  logic [31:0] held_start;
  logic [23:0] held_idx;
  logic        seen_earlier;

  task automatic clear_read();
    next_start   = 0;
    hit_cnt      = '0;
    held_v       = 1'b0;
    held_start   = '0;
    held_idx     = '0;
    seen_earlier = 1'b0;
  endtask

  task automatic report(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want_v, got_v, $time);
  endtask

  task automatic plan_hit(input logic [31:0] pos, input logic fin);
    longint      hit, lim, csz, cbf, caf, open_at, nxt, aligned;
    logic [23:0] idx;
    logic [31:0] emit_start;
    hit = pos;
    lim = sl;
    csz = cs;
    cbf = cb;
    caf = ca;
    idx = hit_cnt;
    hit_cnt = hit_cnt + 1'b1;
    if (next_start < lim && hit >= next_start) begin
      open_at = hit - cbf;
      if (open_at < 0) open_at = 0;
      if (held_v) begin
        chunk_q.insert(chunk_q.size(), chunk_t'{held_start, held_idx, 1'b0});
        seen_earlier = 1'b1;
      end
      held_v     = 1'b1;
      held_start = open_at[31:0];
      held_idx   = idx;
      nxt = open_at + csz - caf + 1;
      // always step past the hit, even when trailing context eats the window
      if (nxt <= hit) nxt = hit + 1;
      next_start = nxt;
    end
    if (fin) begin
      if (held_v) begin
        emit_start = held_start;
        if (seen_earlier && ea) begin
          aligned = hit + caf - csz;
          if (aligned > 0) begin
            if (aligned > POS_MAX) aligned = POS_MAX;
            emit_start = aligned[31:0];
          end
        end
        chunk_q.insert(chunk_q.size(), chunk_t'{emit_start, held_idx, 1'b1});
      end
      clear_read();
    end
  endtask

  always @(posedge clk) begin
    chunk_t      want;
    logic [31:0] rd_want;
    if (rst) begin
      cs = WIN_LEN_RESET;
      cb = '0;
      ca = '0;
      ea = 1'b0;
      sl = '0;
      clear_read();
      chunk_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (cwcp_reg_t'(paddr[4:2]))
            REG_WIN_LEN:        cs = pwdata[15:0];
            REG_CONTEXT_BEFORE: cb = pwdata[15:0];
            REG_CONTEXT_AFTER:  ca = pwdata[15:0];
            REG_END_ALIGN:      ea = pwdata[0];
            REG_SIGNAL_LENGTH:  sl = pwdata;
            default: ;
          endcase
        end else if (paddr[4:2] <= REG_SIGNAL_LENGTH) begin
          case (cwcp_reg_t'(paddr[4:2]))
            REG_WIN_LEN:        rd_want = {16'b0, cs};
            REG_CONTEXT_BEFORE: rd_want = {16'b0, cb};
            REG_CONTEXT_AFTER:  rd_want = {16'b0, ca};
            REG_END_ALIGN:      rd_want = {31'b0, ea};
            default:            rd_want = sl;
          endcase
          if (prdata !== rd_want) report("register readback", rd_want, prdata);
        end
      end
      if (s_tvalid && s_tready) begin
        plan_hit(s_tdata, s_tlast);
        hits_seen++;
      end
      if (m_tvalid && m_tready) begin
        chunks_seen++;
        if (chunk_q.size() == 0) begin
          report("chunk transfer with nothing pending", '0, m_tdata[31:0]);
        end else begin
          want = chunk_q.pop_front();
          if (m_tdata[31:0] !== want.start)
            report("window begin", want.start, m_tdata[31:0]);
          if (m_tdata[55:32] !== want.hit_idx)
            report("first_hit_index", {8'b0, want.hit_idx}, {8'b0, m_tdata[55:32]});
          if (m_tlast !== want.last)
            report("last_chunk", {31'b0, want.last}, {31'b0, m_tlast});
        end
      end
    end
    pending = chunk_q.size();
  end

endmodule

/* verif/tb_context_window_chunk_planner.sv */
// Testbench top for the chunk planner: clock, reset, stimulus and final verdict.
module tb_context_window_chunk_planner;
  timeunit 1ns;
  timeprecision 1ps;
  import cwcp_pkg::*;

  localparam int          LIMIT_CYCLES    = 400000;
  localparam int          LONG_HOLD       = 300;
  localparam int          SETTLE_CYCLES   = 12;
  localparam int          PHASES          = 9;
  localparam int          PHASE_ITEMS     = 145;
  localparam logic [2:0]  REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  REG_SPARE_LAST  = 3'd7;
  localparam logic [31:0] POS_TOP         = 32'hFFFF_FFFF;
  localparam longint      POS_CEIL        = 64'hFFFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // hit_position
  logic                 s_tlast = 1'b0; // final hit of the read
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [55:0]          m_tdata;        // window begin, first_hit_index
  logic                 m_tlast;        // last_chunk

  int fail_count, pending, chunks_seen, hits_seen;
  int cycles = 0;
  int settings_used = 0;
  bit quiet_tail = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #10 clk = ~clk;

  context_window_chunk_planner u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  cwcp_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .pending     (pending),
    .chunks_seen (chunks_seen),
    .hits_seen   (hits_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_context_window_chunk_planner: done, errors");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper bits carry junk; the block must drop them
  task automatic set_config(input logic [15:0] csz, input logic [15:0] before_ctx,
                            input logic [15:0] after_ctx, input logic align,
                            input logic [31:0] sig_len);
    apb_access(1'b1, REG_WIN_LEN, {16'($urandom), csz});
    apb_access(1'b1, REG_CONTEXT_BEFORE, {16'($urandom), before_ctx});
    apb_access(1'b1, REG_CONTEXT_AFTER, {16'($urandom), after_ctx});
    apb_access(1'b1, REG_END_ALIGN, {31'($urandom), align});
    apb_access(1'b1, REG_SIGNAL_LENGTH, sig_len);
    settings_used++;
  endtask

  task automatic read_back();
    for (int r = REG_WIN_LEN; r <= REG_SIGNAL_LENGTH; r++)
      apb_access(1'b0, 3'(r), '0);
  endtask

  task automatic send_hit(input logic [31:0] pos, input logic fin);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pos;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // wait for every chunk, then for hits still in flight that make none
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one read: non-decreasing hits, last flag on the final one; scrambled reads break the order
  task automatic send_read(input longint base, input int n, input int gap_max, input bit scramble);
    longint pos;
    pos = base;
    for (int k = 0; k < n; k++) begin
      if (k > 0) pos += $urandom_range(0, gap_max);
      if (pos > POS_CEIL) pos = POS_CEIL;
      if (scramble && $urandom_range(0, 3) == 0)
        send_hit($urandom, k == n - 1);
      else
        send_hit(pos[31:0], k == n - 1);
    end
  endtask

  task automatic random_phase(input int kind, input int items);
    int          sent, n, pick, csz, gap;
    logic [15:0] before_ctx, after_ctx;
    logic [31:0] sig_len;
    longint      base;
    case (kind)
      0: begin
        csz = 1;
        before_ctx = '0;
        after_ctx = '0;
      end
      1: begin
        csz = 65535;
        before_ctx = 16'hFFFF;
        after_ctx = 16'hFFFF;
      end
      2: begin
        csz = 0;
        before_ctx = 16'($urandom_range(0, 40));
        after_ctx = 16'($urandom_range(0, 40));
      end
      default: begin
        csz = $urandom_range(1, 400);
        before_ctx = 16'($urandom_range(0, csz));
        after_ctx = 16'($urandom_range(0, csz + csz / 4));
        if ($urandom_range(0, 4) == 0) before_ctx = 16'($urandom);
      end
    endcase
    case ($urandom_range(0, 5))
      0: sig_len = POS_TOP;
      1: sig_len = $urandom_range(0, csz + 1);
      default: sig_len = csz * $urandom_range(4, 40) + $urandom_range(0, csz);
    endcase
    set_config(16'(csz), before_ctx, after_ctx, 1'($urandom), sig_len);
    gap = csz + csz / 2 + 1;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_hit($urandom, $urandom_range(0, 7) == 0);
        sent++;
      end else begin
        n = $urandom_range(1, 12);
        if (pick == 1 || sig_len == POS_TOP) base = longint'($urandom);
        else base = $urandom_range(0, sig_len / 2);
        send_read(base, n, gap, pick == 2);
        sent += n;
      end
    end
    settle();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: signal length zero, so a read makes no chunk
    send_hit(32'd0, 1'b0);
    send_hit(32'd100, 1'b1);
    settle();
    read_back();
    for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
      apb_access(1'b1, 3'(r), $urandom);

    // zero chunk size, trailing context wider than the window, aligned start saturates
    set_config(16'd0, 16'd0, 16'hFFFF, 1'b1, POS_TOP);
    send_hit(32'd10, 1'b0);
    send_hit(32'd10, 1'b0);
    send_hit(32'd5, 1'b0);
    send_hit(32'd11, 1'b0);
    send_hit(POS_TOP, 1'b1);
    settle();

    // widest window and lead-in, start clamps at zero, no alignment
    set_config(16'hFFFF, 16'hFFFF, 16'd0, 1'b0, POS_TOP);
    send_hit(32'd0, 1'b0);
    send_hit(32'd100, 1'b0);
    send_hit(32'd70000, 1'b0);
    send_hit(32'h8000_0000, 1'b1);
    settle();

    // hits past signal length, single-chunk read, alignment that comes out non-positive
    set_config(16'd100, 16'd10, 16'd20, 1'b1, 32'd1000);
    send_hit(32'd5, 1'b0);
    send_hit(32'd50, 1'b0);
    send_hit(32'd200, 1'b0);
    send_hit(32'd995, 1'b0);
    send_hit(32'd1500, 1'b0);
    send_hit(32'd1600, 1'b1);
    send_hit(32'd30, 1'b1);
    send_hit(32'd5, 1'b0);
    send_hit(32'd90, 1'b0);
    send_hit(32'd10, 1'b1);
    settle();
    read_back();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) hold_req = 1'b1;
      if (p == PHASES - 1) quiet_tail = 1'b1;
      random_phase(p, PHASE_ITEMS);
    end
    read_back();
    settle();

    $display("run covered %0d hits under %0d register settings, %0d chunks compared",
             hits_seen, settings_used, chunks_seen);
    if (fail_count == 0 && pending == 0)
      $display("tb_context_window_chunk_planner: done, clean");
    else
      $display("tb_context_window_chunk_planner: done, errors");
    $finish;
  end

endmodule
